// ===== rtl/skvt_pkg.sv =====
// Shared types and constants for the sorted key/value table.
package skvt_pkg;

   localparam int OP_W = 2;
   localparam int KEY_W = 64;
   localparam int VAL_W = 64;
   localparam int STATUS_W = 2;
   localparam int CNT_W = 7;
   localparam int DEPTH_DEFAULT = 64;
   localparam int CNT_MAX = (1 << CNT_W) - 1;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

   localparam logic [OP_W-1:0] OP_SET = 2'd0;
   localparam logic [OP_W-1:0] OP_GET = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DONE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [VAL_W-1:0]    read_value;
      logic [CNT_W-1:0]    entry_total;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

endpackage

// ===== rtl/skvt_chan_if.sv =====
// Valid/ready channel interface used for requests, responses and register writes.
interface skvt_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sorted_key_value_table_unit.sv =====
// Top level of the sorted key/value table with its capacity register and response register.
//
// The table holds up to DEPTH pairs of 64-bit keys and values in ascending key order in a
// single-port-read memory. A request is taken only when the sequencer is idle. Every lookup
// reads one stored entry per cycle through the memory's one read port. A search stops at the
// first stored key that is equal to or greater than the request key, or after the last entry.
// An insertion then moves each larger entry up one place, one entry per cycle through the
// same read and write ports, and writes the new pair into the freed place. The longest
// request is an insertion into a table that holds DEPTH - 1 entries. A clear or an undefined
// request skips the search. When the response is taken at once, the next request can be
// taken at the edge of the response transfer. The capacity register may be written at any
// time the block is idle and takes effect on the next request; a value above DEPTH acts as
// DEPTH.
module sorted_key_value_table_unit
   import skvt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   skvt_chan_if.sink   req_port,
   skvt_chan_if.source rsp_port,
   skvt_chan_if.sink   csr_port
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CNT_W-1:0] cap_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             done_valid;
   logic             done_ready;
   rsp_type          done_data;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   entry_type        mem_rd_data;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_port.valid) begin
         cap_ff <= csr_port.payload;
      end
   end

   assign done_ready = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = done_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.payload = rsp_data_ff;

   skvt_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_port.valid),
      .req_data    (req_port.payload),
      .req_ready   (req_port.ready),
      .capacity    (cap_ff),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_data   (done_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   skvt_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== rtl/skvt_mem.sv =====
// Table storage: one write port and one registered read port.
module skvt_mem
   import skvt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/skvt_ctrl.sv =====
// Sequencer that searches, updates, shifts and clears the table, comparing each entry read against the request key.
module skvt_ctrl
   import skvt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_data,
   output logic             req_ready,
   input  logic [CNT_W-1:0] capacity,
   output logic             done_valid,
   input  logic             done_ready,
   output rsp_type          done_data,
   output logic             mem_wr_en,
   output logic [AW-1:0]    mem_wr_addr,
   output entry_type        mem_wr_data,
   output logic             mem_rd_en,
   output logic [AW-1:0]    mem_rd_addr,
   input  entry_type        mem_rd_data
);

   localparam int CAP_LIMIT = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   rsp_type          res_ff, res_in;

   logic             key_eq;
   logic             key_gt;
   logic [CNT_W-1:0] cap_eff;
   logic             resolve;
   logic             hit;
   logic [CNT_W-1:0] pos_sel;

   assign key_eq = (mem_rd_data.key == key_ff);
   assign key_gt = (mem_rd_data.key > key_ff);
   assign cap_eff = (capacity > CNT_W'(CAP_LIMIT)) ? CNT_W'(CAP_LIMIT) : capacity;

   always_comb begin
      resolve = 1'b0;
      hit = 1'b0;
      pos_sel = count_ff;
      if (pend_ff && (key_eq || key_gt)) begin
         resolve = 1'b1;
         hit = key_eq;
         pos_sel = pidx_ff;
      end else if (!pend_ff && (idx_ff == count_ff)) begin
         resolve = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pend_in = pend_ff;
      pidx_in = pidx_ff;
      pos_in = pos_ff;
      res_in = res_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en = 1'b0;
      mem_rd_addr = '0;
      req_ready = (state_ff == S_IDLE);
      done_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_data.op;
               key_in = req_data.key;
               value_in = req_data.value;
               idx_in = '0;
               pend_in = 1'b0;
               res_in.status = ST_DONE;
               res_in.found = 1'b0;
               res_in.read_value = '0;
               res_in.entry_total = count_ff;
               case (req_data.op)
                  OP_SET, OP_GET: begin
                     state_in = S_SEARCH;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     res_in.entry_total = '0;
                     state_in = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (!resolve) begin
               pend_in = (idx_ff < count_ff);
               if (idx_ff < count_ff) begin
                  mem_rd_en = 1'b1;
                  mem_rd_addr = AW'(idx_ff);
                  pidx_in = idx_ff;
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
               state_in = S_FINISH;
               if (op_ff == OP_GET) begin
                  if (hit) begin
                     res_in.found = 1'b1;
                     res_in.read_value = mem_rd_data.value;
                  end
               end else if (hit) begin
                  mem_wr_en = 1'b1;
                  mem_wr_addr = AW'(pos_sel);
                  mem_wr_data.key = key_ff;
                  mem_wr_data.value = value_ff;
                  res_in.status = ST_UPDATED;
                  res_in.found = 1'b1;
               end else if (count_ff >= cap_eff) begin
                  res_in.status = ST_FULL;
               end else begin
                  pos_in = pos_sel;
                  idx_in = count_ff;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
               mem_wr_addr = AW'(pidx_ff);
               mem_wr_data = mem_rd_data;
            end
            if (idx_ff != pos_ff) begin
               mem_rd_en = 1'b1;
               mem_rd_addr = AW'(CNT_W'(idx_ff - 1'b1));
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in = idx_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  mem_wr_en = 1'b1;
                  mem_wr_addr = AW'(pos_ff);
                  mem_wr_data.key = key_ff;
                  mem_wr_data.value = value_ff;
                  count_in = count_ff + 1'b1;
                  res_in.status = ST_INSERTED;
                  res_in.entry_total = count_ff + 1'b1;
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      key_ff <= key_in;
      value_ff <= value_in;
      idx_ff <= idx_in;
      pidx_ff <= pidx_in;
      pos_ff <= pos_in;
      res_ff <= res_in;
   end

   assign done_data = res_ff;

endmodule
